>>> rtl/core/command_packet_parser_defines.svh
// Assertion macros shared by the command packet parser RTL.
`ifndef COMMAND_PACKET_PARSER_DEFINES_SVH
`define COMMAND_PACKET_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define CPP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("command packet parser: same-cycle check failed");

// Next-cycle implication, sampled on clk, idle during reset.
`define CPP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("command packet parser: next-cycle check failed");

`endif

>>> rtl/core/cpp_pkg.sv
// Shared constants, types and the type-character decoder of the command packet parser.
package cpp_pkg;

	// Payload storage bound (bytes) and length field width
	localparam int MAX_PAYLOAD_DEF = 16;
	localparam int LEN_W           = 5;

	// Framing characters
	localparam logic [7:0] CH_START = 8'h21; // '!'
	localparam logic [7:0] CH_Q     = 8'h51; // quaternion
	localparam logic [7:0] CH_A     = 8'h41; // accelerometer
	localparam logic [7:0] CH_G     = 8'h47; // gyro
	localparam logic [7:0] CH_M     = 8'h4D; // magnetometer
	localparam logic [7:0] CH_L     = 8'h4C; // location
	localparam logic [7:0] CH_B     = 8'h42; // button

	// Payload lengths per type
	localparam logic [LEN_W-1:0] LEN_QUAT   = LEN_W'(4 * 4);
	localparam logic [LEN_W-1:0] LEN_VECTOR = LEN_W'(3 * 4);
	localparam logic [LEN_W-1:0] LEN_BUTTON = LEN_W'(2);

	// Result status codes
	localparam logic [1:0] ST_GOOD     = 2'd0;
	localparam logic [1:0] ST_BAD_SUM  = 2'd1;
	localparam logic [1:0] ST_BAD_TYPE = 2'd2;

	typedef struct packed {
		logic             known;
		logic [LEN_W-1:0] len;
	} type_info_t;

	// Control from the parser to the payload store
	typedef struct packed {
		logic clear;
		logic wr_en;
	} store_ctrl_t;

	// Decode a type character; length saturates at len_max
	function automatic type_info_t type_decode(logic [7:0] t, logic [LEN_W-1:0] len_max);
		type_info_t info;
		info.known = 1'b1;
		unique case (t) inside
			CH_Q:                   info.len = LEN_QUAT;
			CH_A, CH_G, CH_M, CH_L: info.len = LEN_VECTOR;
			CH_B:                   info.len = LEN_BUTTON;
			default: begin
				info.known = 1'b0;
				info.len   = '0;
			end
		endcase
		if (info.len > len_max) begin
			info.len = len_max;
		end
		return info;
	endfunction

endpackage

>>> rtl/core/cpp_payload_store.sv
// Payload byte store of the command packet parser: clear on packet start, one write per word.
module cpp_payload_store #(
	parameter int MAX_PAYLOAD = cpp_pkg::MAX_PAYLOAD_DEF,
	parameter int IDX_W       = $clog2(MAX_PAYLOAD)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cpp_pkg::store_ctrl_t       ctrl,
	input  logic [IDX_W-1:0]           wr_idx,
	input  logic [7:0]                 wr_data,
	output logic [8*MAX_PAYLOAD-1:0]   rd_flat
);
	import cpp_pkg::*;

	logic [7:0] bytes_q [MAX_PAYLOAD];

	// Byte registers: whole-store clear wins over a write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_PAYLOAD; i++) begin
				bytes_q[i] <= '0;
			end
		end else if (ctrl.clear) begin
			for (int i = 0; i < MAX_PAYLOAD; i++) begin
				bytes_q[i] <= '0;
			end
		end else if (ctrl.wr_en) begin
			bytes_q[wr_idx] <= wr_data;
		end
	end

	// Flatten, byte 0 in the low bits
	always_comb begin
		for (int i = 0; i < MAX_PAYLOAD; i++) begin
			rd_flat[8*i +: 8] = bytes_q[i];
		end
	end

endmodule

>>> rtl/core/command_packet_parser.sv
// Command packet parser top level: framing FSM, checksum and result register.
//
// Usage:
//   Received serial bytes enter one word per handshake on rx_byte (in_valid /
//   in_ready). Packets are '!', a type character, a payload whose length the
//   type sets (Q: 16, A/G/M/L: 12, B: 2) and a checksum equal to the inverted
//   8-bit sum of all earlier bytes. Idle bytes other than '!' are dropped.
//   One result word per packet leaves on out_valid / out_ready with the type,
//   the 16-byte payload split in two 64-bit halves, the length and a status
//   (good, checksum mismatch, unknown type; an unknown type ends the packet).
// Latency and throughput:
//   One input word per cycle unless stalled. A result is valid in the cycle
//   after the word that ends the packet (checksum or bad type) is accepted.
//   All per-word work is one compare, one 8-bit add and one byte write,
//   finished in the accept cycle; the result register is the only stage.
// Reset:
//   arst_n clears the FSM, running sum, payload store and result register.
// Stall:
//   While a result waits and out_ready is low, in_ready is low; a taken result
//   frees the register in the same cycle, so input flow continues unbroken.
module command_packet_parser #(
	parameter int MAX_PAYLOAD = cpp_pkg::MAX_PAYLOAD_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                rx_byte,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [7:0]                packet_type,
	output logic [63:0]               payload_low,
	output logic [63:0]               payload_high,
	output logic [cpp_pkg::LEN_W-1:0] payload_length,
	output logic [1:0]                status
);
	import cpp_pkg::*;

	`include "command_packet_parser_defines.svh"

	localparam int               IDX_W   = $clog2(MAX_PAYLOAD);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PAYLOAD);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_TYPE,
		PH_DATA
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [7:0]         type_q, type_d;
	logic [LEN_W-1:0]   len_q, len_d;
	logic [LEN_W-1:0]   left_q, left_d;
	logic [7:0]         sum_q, sum_d;

	logic               out_valid_q;
	logic [7:0]         res_type_q;
	logic [127:0]       res_payload_q;
	logic [LEN_W-1:0]   res_len_q;
	logic [1:0]         res_status_q;

	logic               accept;
	logic               res_fire;
	logic [7:0]         res_type;
	logic               res_use_store;
	logic [LEN_W-1:0]   res_len;
	logic [1:0]         res_status;
	type_info_t         tinfo;
	store_ctrl_t        st_ctrl;
	logic [LEN_W-1:0]   wr_pos;
	logic [8*MAX_PAYLOAD-1:0] store_flat;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;
	assign tinfo    = type_decode(rx_byte, LEN_MAX);
	// Store position of the current payload word
	assign wr_pos   = len_q - left_q + LEN_W'(1);

	cpp_payload_store #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.IDX_W       (IDX_W)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (st_ctrl),
		.wr_idx  (wr_pos[IDX_W-1:0]),
		.wr_data (rx_byte),
		.rd_flat (store_flat)
	);

	// Per-word parse step
	always_comb begin
		phase_d       = phase_q;
		type_d        = type_q;
		len_d         = len_q;
		left_d        = left_q;
		sum_d         = sum_q;
		st_ctrl       = '0;
		res_fire      = 1'b0;
		res_type      = type_q;
		res_use_store = 1'b0;
		res_len       = '0;
		res_status    = ST_GOOD;
		if (accept) begin
			unique case (phase_q)
				PH_TYPE: begin
					type_d = rx_byte;
					sum_d  = sum_q + rx_byte;
					if (!tinfo.known) begin
						phase_d    = PH_IDLE;
						res_fire   = 1'b1;
						res_type   = rx_byte;
						res_status = ST_BAD_TYPE;
					end else begin
						phase_d = PH_DATA;
						len_d   = tinfo.len;
						left_d  = tinfo.len + LEN_W'(1);
					end
				end
				PH_DATA: begin
					if (left_q > LEN_W'(1)) begin
						st_ctrl.wr_en = 1'b1;
						sum_d         = sum_q + rx_byte;
						left_d        = left_q - LEN_W'(1);
					end else begin
						// checksum word closes the packet
						left_d        = '0;
						phase_d       = PH_IDLE;
						res_fire      = 1'b1;
						res_use_store = 1'b1;
						res_len       = len_q;
						res_status    = (rx_byte == ~sum_q) ? ST_GOOD : ST_BAD_SUM;
					end
				end
				default: begin
					phase_d = PH_IDLE;
					if (rx_byte == CH_START) begin
						phase_d       = PH_TYPE;
						sum_d         = rx_byte;
						type_d        = '0;
						left_d        = '0;
						st_ctrl.clear = 1'b1;
					end
				end
			endcase
		end
	end

	// Parser state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			type_q        <= '0;
			len_q         <= '0;
			left_q        <= '0;
			sum_q         <= '0;
			out_valid_q   <= 1'b0;
			res_type_q    <= '0;
			res_payload_q <= '0;
			res_len_q     <= '0;
			res_status_q  <= ST_GOOD;
		end else begin
			phase_q <= phase_d;
			type_q  <= type_d;
			len_q   <= len_d;
			left_q  <= left_d;
			sum_q   <= sum_d;
			if (res_fire) begin
				out_valid_q   <= 1'b1;
				res_type_q    <= res_type;
				res_payload_q <= res_use_store ? 128'(store_flat) : '0;
				res_len_q     <= res_len;
				res_status_q  <= res_status;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign packet_type    = res_type_q;
	assign payload_low    = res_payload_q[63:0];
	assign payload_high   = res_payload_q[127:64];
	assign payload_length = res_len_q;
	assign status         = res_status_q;

	// Checks
	`CPP_ASSERT_NEXT(a_csum_word_gives_result,
		accept && phase_q == PH_DATA && left_q <= LEN_W'(1), out_valid_q)
	`CPP_ASSERT_IMPL(a_data_count_live, phase_q == PH_DATA, left_q != '0)
	`CPP_ASSERT_IMPL(a_bad_type_empty,
		out_valid_q && res_status_q == ST_BAD_TYPE,
		res_len_q == '0 && res_payload_q == '0)
	`CPP_ASSERT_IMPL(a_len_bounded, out_valid_q, res_len_q <= LEN_MAX)

endmodule
